/* hw/rtl/hts_pkg.sv */
// Shared types, codes and helpers for the hold-to-secondary-click block.
`timescale 1ns / 1ps

package hts_pkg;

   // input event codes
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_DOWN   = 3'd1;
   localparam logic [2:0] OP_UP     = 3'd2;
   localparam logic [2:0] OP_MOTION = 3'd3;
   localparam logic [2:0] OP_OTHER  = 3'd4;
   localparam logic [2:0] OP_NONPTR = 3'd5;

   // result kinds
   localparam logic [2:0] KIND_PASS      = 3'd0;
   localparam logic [2:0] KIND_CONSUME   = 3'd1;
   localparam logic [2:0] KIND_SYN_DOWN  = 3'd2;
   localparam logic [2:0] KIND_SYN_UP    = 3'd3;
   localparam logic [2:0] KIND_HELD_DOWN = 3'd4;
   localparam logic [2:0] KIND_MOTION    = 3'd5;

   // notify codes
   localparam logic [1:0] NOTE_NONE     = 2'd0;
   localparam logic [1:0] NOTE_STARTED  = 2'd1;
   localparam logic [1:0] NOTE_CANCELED = 2'd2;
   localparam logic [1:0] NOTE_FIRED    = 2'd3;

   localparam logic [7:0] BTN_NONE      = 8'h00;
   localparam logic [7:0] BTN_PRIMARY   = 8'h01;
   localparam logic [7:0] BTN_SECONDARY = 8'h02;

   // register indexes
   localparam logic CSR_HOLD_TICKS    = 1'b0;
   localparam logic CSR_MOTION_RADIUS = 1'b1;

   localparam logic [15:0] HOLD_TICKS_RESET    = 16'd1000;
   localparam logic [15:0] MOTION_RADIUS_RESET = 16'd80;

   localparam int RES_MAX = 3;

   typedef struct packed {
      logic [2:0]         op;
      logic [7:0]         buttons;
      logic               has_pos;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [31:0]        stamp;
   } item_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         buttons;
      logic               has_pos;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        stamp;
      logic [1:0]         notify;
      logic               last;
   } result_type;

   typedef struct packed {
      logic [1:0]                 count;
      result_type [RES_MAX-1:0]   entry;
   } res_set_type;

   typedef struct packed {
      logic [15:0] hold_ticks;
      logic [15:0] motion_radius;
   } cfg_type;

   // pass/consume verdict: payload fields are zero
   function automatic result_type verdict_result(logic [2:0] kind, logic [1:0] note);
      result_type r;
      r        = '0;
      r.kind   = kind;
      r.notify = note;
      r.last   = 1'b1;
      return r;
   endfunction

   // synthesized button event: no position, stamped with the causing item's time
   function automatic result_type synth_result(logic [2:0] kind, logic [7:0] btn,
                                               logic [31:0] stamp, logic [1:0] note,
                                               logic last);
      result_type r;
      r         = '0;
      r.kind    = kind;
      r.buttons = btn;
      r.stamp   = stamp;
      r.notify  = note;
      r.last    = last;
      return r;
   endfunction

endpackage

/* hw/rtl/hold_to_secondary_click.sv */
// Top level: converts a long primary-button hold into a secondary click.
`timescale 1ns / 1ps

// Usage
//   req_*  : one pointer/tick event item per handshake (valid/ready).
//   rsp_*  : result items, one per handshake; rsp_last marks the end of the
//            run that one input item causes (1 to 3 results, ticks may give 0).
//   csr_*  : write-only registers, index 0 hold_ticks, index 1 motion_radius.
//            Write only while no item is in flight.
// Timing
//   An accepted item lands in the input register, is evaluated once the
//   result buffer is free and its results are loaded into the result
//   buffer, from which the first result can be taken.
//   Throughput: one item per cycle while each item yields one result and
//   rsp_ready is high; a run of k results holds the output until the
//   buffer drains it, one result per cycle while rsp_ready is high.
// Reset
//   Synchronous, active high: gesture back to waiting for a primary down,
//   countdown cleared, registers back to 1000 ticks / 80 (5.0 px).
// Backpressure
//   While rsp_ready is low the run waits in the buffer; the input register
//   still takes one more item, then req_ready drops.

module hold_to_secondary_click (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic [7:0]         req_buttons,
   input  logic               req_has_pos,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [31:0]        req_stamp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_out_buttons,
   output logic               rsp_out_has_pos,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic [31:0]        rsp_out_time,
   output logic [1:0]         rsp_notify,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);
   import hts_pkg::*;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks    <= HOLD_TICKS_RESET;
         cfg_ff.motion_radius <= MOTION_RADIUS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HOLD_TICKS:    cfg_ff.hold_ticks    <= csr_wdata;
            CSR_MOTION_RADIUS: cfg_ff.motion_radius <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic        in_vld_ff;
   item_type    in_item_ff;
   logic        buf_free;
   logic        step_go;
   res_set_type set;
   result_type  rsp;

   assign step_go   = in_vld_ff && buf_free;
   assign req_ready = !in_vld_ff || step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_vld_ff <= 1'b1;
      end else if (step_go) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.op      <= req_op;
         in_item_ff.buttons <= req_buttons;
         in_item_ff.has_pos <= req_has_pos;
         in_item_ff.pos_x   <= req_pos_x;
         in_item_ff.pos_y   <= req_pos_y;
         in_item_ff.stamp   <= req_stamp;
      end
   end

   // evaluation: gesture state plus the run of results for this item
   hts_core u_core (
      .clock (clock),
      .reset (reset),
      .go    (step_go),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .set   (set)
   );

   // an empty run (quiet tick) updates state without touching the buffer
   hts_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (step_go && (set.count != 2'd0)),
      .set       (set),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_kind        = rsp.kind;
   assign rsp_out_buttons = rsp.buttons;
   assign rsp_out_has_pos = rsp.has_pos;
   assign rsp_out_x       = rsp.x;
   assign rsp_out_y       = rsp.y;
   assign rsp_out_time    = rsp.stamp;
   assign rsp_notify      = rsp.notify;
   assign rsp_last        = rsp.last;

endmodule

/* hw/rtl/hts_core.sv */
// Gesture state and combinational result generation for one event item.
`timescale 1ns / 1ps

module hts_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  hts_pkg::item_type    item,
   input  hts_pkg::cfg_type     cfg,
   output hts_pkg::res_set_type set
);
   import hts_pkg::*;

   typedef enum logic [3:0] {
      MODE_WAIT_DOWN  = 4'b0001,
      MODE_HOLDING    = 4'b0010,
      MODE_SWALLOW_UP = 4'b0100,
      MODE_DRAG       = 4'b1000
   } mode_type;

   mode_type           mode_ff, mode_in;
   logic               pend_ff, pend_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic signed [15:0] anchor_x_ff, anchor_x_in;
   logic signed [15:0] anchor_y_ff, anchor_y_in;
   logic [7:0]         held_btn_ff, held_btn_in;
   logic               held_hp_ff, held_hp_in;
   logic signed [15:0] held_x_ff, held_x_in;
   logic signed [15:0] held_y_ff, held_y_in;

   // squared travel from the anchor against squared radius
   logic signed [16:0] dx, dy;
   logic signed [33:0] dx_sq, dy_sq;
   logic [32:0]        d2;
   logic [31:0]        r2;
   logic               outside;

   assign dx      = $signed({item.pos_x[15], item.pos_x}) - $signed({anchor_x_ff[15], anchor_x_ff});
   assign dy      = $signed({item.pos_y[15], item.pos_y}) - $signed({anchor_y_ff[15], anchor_y_ff});
   assign dx_sq   = dx * dx;
   assign dy_sq   = dy * dy;
   assign d2      = {1'b0, dx_sq[31:0]} + {1'b0, dy_sq[31:0]};
   assign r2      = cfg.motion_radius * cfg.motion_radius;
   assign outside = item.has_pos && (d2 > {1'b0, r2});

   logic        pre_two;
   result_type  pre0, pre1;
   logic [2:0]  verdict;
   logic [1:0]  vnote;

   always_comb begin
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      held_btn_in = held_btn_ff;
      held_hp_in  = held_hp_ff;
      held_x_in   = held_x_ff;
      held_y_in   = held_y_ff;
      set         = '0;
      pre_two     = 1'b0;
      pre0        = '0;
      pre1        = '0;
      verdict     = KIND_PASS;
      vnote       = NOTE_NONE;

      if (item.op == OP_TICK) begin
         if (pend_ff) begin
            if (cnt_ff > 16'd1) begin
               cnt_in = cnt_ff - 16'd1;
            end else begin
               pend_in      = 1'b0;
               cnt_in       = '0;
               mode_in      = MODE_SWALLOW_UP;
               set.count    = 2'd2;
               set.entry[0] = synth_result(KIND_SYN_DOWN, BTN_SECONDARY, item.stamp,
                                           NOTE_NONE, 1'b0);
               set.entry[1] = synth_result(KIND_SYN_UP, BTN_NONE, item.stamp,
                                           NOTE_FIRED, 1'b1);
            end
         end
      end else begin
         case (item.op) inside
            OP_DOWN, OP_UP, OP_MOTION, OP_OTHER: begin
               unique case (mode_ff)
                  MODE_WAIT_DOWN: begin
                     if (item.op == OP_DOWN && item.buttons[0]) begin
                        held_btn_in = item.buttons;
                        held_hp_in  = item.has_pos;
                        held_x_in   = item.pos_x;
                        held_y_in   = item.pos_y;
                        if (item.has_pos) begin
                           anchor_x_in = item.pos_x;
                           anchor_y_in = item.pos_y;
                        end
                        pend_in = 1'b1;
                        cnt_in  = cfg.hold_ticks;
                        mode_in = MODE_HOLDING;
                        verdict = KIND_CONSUME;
                        vnote   = NOTE_STARTED;
                     end
                  end
                  MODE_HOLDING: begin
                     if (item.op == OP_MOTION) begin
                        verdict = KIND_CONSUME;
                        if (outside) begin
                           pend_in      = 1'b0;
                           cnt_in       = '0;
                           mode_in      = MODE_DRAG;
                           pre_two      = 1'b1;
                           pre0.kind    = KIND_HELD_DOWN;
                           pre0.buttons = held_btn_ff;
                           pre0.has_pos = held_hp_ff;
                           pre0.x       = held_x_ff;
                           pre0.y       = held_y_ff;
                           pre0.stamp   = item.stamp;
                           pre0.notify  = pend_ff ? NOTE_CANCELED : NOTE_NONE;
                           pre1.kind    = KIND_MOTION;
                           pre1.buttons = item.buttons;
                           pre1.has_pos = item.has_pos;
                           pre1.x       = item.pos_x;
                           pre1.y       = item.pos_y;
                           pre1.stamp   = item.stamp;
                        end
                     end else if (item.op == OP_UP && !item.buttons[0]) begin
                        if (pend_ff) begin
                           pend_in = 1'b0;
                           cnt_in  = '0;
                           pre_two = 1'b1;
                           pre0    = synth_result(KIND_SYN_DOWN, BTN_PRIMARY, item.stamp,
                                                  NOTE_CANCELED, 1'b0);
                           pre1    = synth_result(KIND_SYN_UP, BTN_NONE, item.stamp,
                                                  NOTE_NONE, 1'b0);
                        end
                        mode_in = MODE_WAIT_DOWN;
                        verdict = KIND_CONSUME;
                     end
                  end
                  MODE_SWALLOW_UP: begin
                     if (item.op == OP_UP) begin
                        mode_in = MODE_WAIT_DOWN;
                        verdict = KIND_CONSUME;
                     end
                  end
                  MODE_DRAG: begin
                     if (item.op == OP_UP) begin
                        mode_in = MODE_WAIT_DOWN;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase

         if (pre_two) begin
            set.count    = 2'd3;
            set.entry[0] = pre0;
            set.entry[1] = pre1;
            set.entry[2] = verdict_result(verdict, vnote);
         end else begin
            set.count    = 2'd1;
            set.entry[0] = verdict_result(verdict, vnote);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT_DOWN;
         pend_ff     <= 1'b0;
         cnt_ff      <= '0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         held_btn_ff <= '0;
         held_hp_ff  <= 1'b0;
         held_x_ff   <= '0;
         held_y_ff   <= '0;
      end else if (go) begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         cnt_ff      <= cnt_in;
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         held_btn_ff <= held_btn_in;
         held_hp_ff  <= held_hp_in;
         held_x_ff   <= held_x_in;
         held_y_ff   <= held_y_in;
      end
   end

   // countdown only runs while a down is held back
   a_pend_holding: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (mode_ff == MODE_HOLDING))
      else $error("countdown pending outside holding mode");

   // only ticks may produce an empty run
   a_empty_tick: assert property (@(posedge clock) disable iff (reset)
      (go && set.count == 2'd0) |-> (item.op == OP_TICK))
      else $error("non-tick item produced no result");

endmodule

/* hw/rtl/hts_rsp_buf.sv */
// Result buffer holding one item's run of up to three results.
`timescale 1ns / 1ps

module hts_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hts_pkg::res_set_type set,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hts_pkg::result_type  rsp
);
   import hts_pkg::*;

   logic                     vld_ff, vld_in;
   logic [1:0]               idx_ff, idx_in;
   logic [1:0]               n_ff, n_in;
   result_type [RES_MAX-1:0] ent_ff;
   logic                     at_end;

   assign at_end    = (idx_ff == n_ff - 2'd1);
   assign free      = !vld_ff || (rsp_ready && at_end);
   assign rsp_valid = vld_ff;
   assign rsp       = ent_ff[idx_ff];

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      n_in   = n_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = '0;
         n_in   = set.count;
      end else if (vld_ff && rsp_ready) begin
         if (at_end) begin
            vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
         n_ff   <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
         n_ff   <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= set.entry;
      end
   end

   // last flag must line up with the stored run length
   a_last_align: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (rsp.last == at_end))
      else $error("last flag does not match run length");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (idx_ff < n_ff))
      else $error("read index beyond run length");

endmodule
